@@ rtl/scit_pkg.sv @@
// Shared types, constants and the step schedule of the sphere cluster inertia tensor block.
package scit_pkg;

  localparam int ACC_W     = 48;
  localparam int NUM_SUMS  = 6;
  localparam int SUM_IDX_W = $clog2(NUM_SUMS);
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int TERM_W    = 50;
  localparam int ASUM_W    = ((ACC_W > TERM_W) ? ACC_W : TERM_W) + 1;
  localparam int NUM_STEPS = 20;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  // (4/3) pi * 2^13 and (2/5) * 2^16, both rounded to nearest.
  localparam logic [15:0] K_MASS       = 16'd34315;
  localparam logic [15:0] K_TWO_FIFTHS = 16'd26214;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [ASUM_W-1:0] asum_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [MUL_W-1:0]  mop_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  typedef enum logic [SUM_IDX_W-1:0] {
    SUM_XX,
    SUM_YY,
    SUM_ZZ,
    SUM_XY,
    SUM_XZ,
    SUM_YZ
  } sum_t;

  typedef enum logic [2:0] {
    A_R,
    A_PX,
    A_PY,
    A_PZ,
    A_R2,
    A_M,
    A_THI,
    A_TLO
  } opa_t;

  typedef enum logic [3:0] {
    B_R,
    B_KM,
    B_PX,
    B_PY,
    B_PZ,
    B_RK,
    B_R2,
    B_K2,
    B_OX,
    B_OY,
    B_OZ,
    B_PXY,
    B_PXZ,
    B_PYZ
  } opb_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_R2,
    WB_RK,
    WB_SQX,
    WB_SQY,
    WB_SQZ,
    WB_M,
    WB_T,
    WB_HI,
    WB_S,
    WB_PXY,
    WB_PXZ,
    WB_PYZ,
    WB_TD,
    WB_TO
  } wb_t;

  typedef struct packed {
    opa_t a_sel;
    opb_t b_sel;
    wb_t  wb_sel;
    logic acc_en;
    sum_t acc_idx;
  } op_t;

  typedef struct packed {
    logic load;
    logic emit;
    op_t  op;
  } ctl_t;

  localparam op_t OP_NOP = '{a_sel: A_R, b_sel: B_R, wb_sel: WB_NONE,
                             acc_en: 1'b0, acc_idx: SUM_XX};

  // Steps 0 to 17 each start one product, which the following step writes back from the product register.
  function automatic op_t step_op(input logic [STEP_W-1:0] step);
    op_t op;
    op = OP_NOP;
    case (step)
      5'd0: begin op.a_sel = A_R; op.b_sel = B_R; end
      5'd1: begin op.a_sel = A_R; op.b_sel = B_KM; op.wb_sel = WB_R2; end
      5'd2: begin op.a_sel = A_PX; op.b_sel = B_PX; op.wb_sel = WB_RK; end
      5'd3: begin op.a_sel = A_R2; op.b_sel = B_RK; op.wb_sel = WB_SQX; end
      5'd4: begin op.a_sel = A_PY; op.b_sel = B_PY; op.wb_sel = WB_M; end
      5'd5: begin op.a_sel = A_M; op.b_sel = B_R2; op.wb_sel = WB_SQY; end
      5'd6: begin op.a_sel = A_PZ; op.b_sel = B_PZ; op.wb_sel = WB_T; end
      5'd7: begin op.a_sel = A_THI; op.b_sel = B_K2; op.wb_sel = WB_SQZ; end
      5'd8: begin op.a_sel = A_TLO; op.b_sel = B_K2; op.wb_sel = WB_HI; end
      5'd9: begin op.a_sel = A_PX; op.b_sel = B_PY; op.wb_sel = WB_S; end
      5'd10: begin op.a_sel = A_PX; op.b_sel = B_PZ; op.wb_sel = WB_PXY; end
      5'd11: begin op.a_sel = A_PY; op.b_sel = B_PZ; op.wb_sel = WB_PXZ; end
      5'd12: begin op.a_sel = A_M; op.b_sel = B_OX; op.wb_sel = WB_PYZ; end
      5'd13: begin op.a_sel = A_M; op.b_sel = B_OY; op.wb_sel = WB_TD; end
      5'd14: begin
        op.a_sel = A_M; op.b_sel = B_OZ; op.wb_sel = WB_TD;
        op.acc_en = 1'b1; op.acc_idx = SUM_XX;
      end
      5'd15: begin
        op.a_sel = A_M; op.b_sel = B_PXY; op.wb_sel = WB_TD;
        op.acc_en = 1'b1; op.acc_idx = SUM_YY;
      end
      5'd16: begin
        op.a_sel = A_M; op.b_sel = B_PXZ; op.wb_sel = WB_TO;
        op.acc_en = 1'b1; op.acc_idx = SUM_ZZ;
      end
      5'd17: begin
        op.a_sel = A_M; op.b_sel = B_PYZ; op.wb_sel = WB_TO;
        op.acc_en = 1'b1; op.acc_idx = SUM_XY;
      end
      5'd18: begin
        op.wb_sel = WB_TO;
        op.acc_en = 1'b1; op.acc_idx = SUM_XZ;
      end
      5'd19: begin op.acc_en = 1'b1; op.acc_idx = SUM_YZ; end
      default: op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

@@ rtl/scit_ctrl.sv @@
// Controller: sequences the datapath steps for one sphere and manages both handshakes.
module scit_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              last_atom,
  input  logic              out_stall,
  output logic              in_stall,
  output logic              out_valid,
  output scit_pkg::ctl_t    ctl
);

  scit_pkg::state_t              state;
  scit_pkg::state_t              state_next;
  logic [scit_pkg::STEP_W-1:0]   step;
  logic [scit_pkg::STEP_W-1:0]   step_next;
  logic                          last;
  logic                          out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= scit_pkg::ST_IDLE;
      step      <= '0;
      last      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
      if (ctl.load) begin
        last <= last_atom;
      end
    end
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid;
    ctl.load       = 1'b0;
    ctl.emit       = 1'b0;
    ctl.op         = scit_pkg::OP_NOP;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    case (state)
      scit_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          step_next  = '0;
          state_next = scit_pkg::ST_RUN;
        end
      end
      scit_pkg::ST_RUN: begin
        ctl.op = scit_pkg::step_op(step);
        if (step == scit_pkg::STEP_W'(scit_pkg::NUM_STEPS - 1)) begin
          state_next = last ? scit_pkg::ST_EMIT : scit_pkg::ST_IDLE;
        end else begin
          step_next = step + scit_pkg::STEP_W'(1);
        end
      end
      scit_pkg::ST_EMIT: begin
        // The output register is free now or is being emptied at this edge.
        if (!out_valid || !out_stall) begin
          ctl.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = scit_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = scit_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != scit_pkg::ST_IDLE);

endmodule

@@ rtl/scit_dpath.sv @@
// Datapath: shared multiplier, fixed-point rounding, saturating accumulators and output word.
module scit_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  scit_pkg::ctl_t                      ctl,
  input  logic        [15:0]                  radius,
  input  logic signed [15:0]                  pos_x,
  input  logic signed [15:0]                  pos_y,
  input  logic signed [15:0]                  pos_z,
  output logic signed [scit_pkg::ACC_W-1:0]   inertia_xx,
  output logic signed [scit_pkg::ACC_W-1:0]   inertia_yy,
  output logic signed [scit_pkg::ACC_W-1:0]   inertia_zz,
  output logic signed [scit_pkg::ACC_W-1:0]   inertia_xy,
  output logic signed [scit_pkg::ACC_W-1:0]   inertia_xz,
  output logic signed [scit_pkg::ACC_W-1:0]   inertia_yz
);

  logic        [15:0] r;
  logic signed [15:0] px;
  logic signed [15:0] py;
  logic signed [15:0] pz;
  logic        [31:0] r2;
  logic        [31:0] rk;
  logic        [30:0] m;
  logic        [42:0] t;
  logic        [37:0] hi;
  logic        [42:0] s;
  logic        [30:0] sqx;
  logic        [30:0] sqy;
  logic        [30:0] sqz;
  logic        [31:0] ox;
  logic        [31:0] oy;
  logic        [31:0] oz;
  logic signed [31:0] pxy;
  logic signed [31:0] pxz;
  logic signed [31:0] pyz;

  scit_pkg::mop_t  opa;
  scit_pkg::mop_t  opb;
  scit_pkg::prod_t prod;
  scit_pkg::prod_t term_sum;
  scit_pkg::term_t term;
  scit_pkg::acc_t  acc [scit_pkg::NUM_SUMS];
  scit_pkg::acc_t  acc_new;
  scit_pkg::asum_t acc_sum;

  logic [63:0] m_sum;
  logic [63:0] t_sum;
  logic [59:0] s_sum;
  logic        sat_hi;
  logic        sat_lo;

  always_comb begin
    case (ctl.op.a_sel)
      scit_pkg::A_R:   opa = scit_pkg::mop_t'(r);
      scit_pkg::A_PX:  opa = scit_pkg::mop_t'(px);
      scit_pkg::A_PY:  opa = scit_pkg::mop_t'(py);
      scit_pkg::A_PZ:  opa = scit_pkg::mop_t'(pz);
      scit_pkg::A_R2:  opa = scit_pkg::mop_t'(r2);
      scit_pkg::A_M:   opa = scit_pkg::mop_t'(m);
      scit_pkg::A_THI: opa = scit_pkg::mop_t'(t[42:21]);
      scit_pkg::A_TLO: opa = scit_pkg::mop_t'(t[20:0]);
      default:         opa = scit_pkg::mop_t'(r);
    endcase
    case (ctl.op.b_sel)
      scit_pkg::B_R:   opb = scit_pkg::mop_t'(r);
      scit_pkg::B_KM:  opb = scit_pkg::mop_t'(scit_pkg::K_MASS);
      scit_pkg::B_PX:  opb = scit_pkg::mop_t'(px);
      scit_pkg::B_PY:  opb = scit_pkg::mop_t'(py);
      scit_pkg::B_PZ:  opb = scit_pkg::mop_t'(pz);
      scit_pkg::B_RK:  opb = scit_pkg::mop_t'(rk);
      scit_pkg::B_R2:  opb = scit_pkg::mop_t'(r2);
      scit_pkg::B_K2:  opb = scit_pkg::mop_t'(scit_pkg::K_TWO_FIFTHS);
      scit_pkg::B_OX:  opb = scit_pkg::mop_t'(ox);
      scit_pkg::B_OY:  opb = scit_pkg::mop_t'(oy);
      scit_pkg::B_OZ:  opb = scit_pkg::mop_t'(oz);
      scit_pkg::B_PXY: opb = scit_pkg::mop_t'(pxy);
      scit_pkg::B_PXZ: opb = scit_pkg::mop_t'(pxz);
      scit_pkg::B_PYZ: opb = scit_pkg::mop_t'(pyz);
      default:         opb = scit_pkg::mop_t'(r);
    endcase
  end

  // Rounding adds for the values taken from the product register.
  assign m_sum = prod[63:0] + (64'd1 << 32);
  assign t_sum = prod[63:0] + (64'd1 << 19);
  assign s_sum = {1'b0, hi, 21'd0} + 60'(prod[36:0]) + 60'd32768;

  // A diagonal term folds the self inertia in above the rounding half, so one add serves;
  // an off-diagonal term is negated before it is rounded.
  always_comb begin
    if (ctl.op.wb_sel == scit_pkg::WB_TO) begin
      term_sum = scit_pkg::prod_t'(32768) - prod;
    end else begin
      term_sum = prod + $signed({7'd0, s, 16'h8000});
    end
  end

  assign acc_sum = scit_pkg::asum_t'(acc[ctl.op.acc_idx]) + scit_pkg::asum_t'(term);
  assign sat_hi  = !acc_sum[scit_pkg::ASUM_W-1] &&
                   (|acc_sum[scit_pkg::ASUM_W-2:scit_pkg::ACC_W-1]);
  assign sat_lo  = acc_sum[scit_pkg::ASUM_W-1] &&
                   !(&acc_sum[scit_pkg::ASUM_W-2:scit_pkg::ACC_W-1]);

  always_comb begin
    if (sat_hi) begin
      acc_new = scit_pkg::ACC_MAX;
    end else if (sat_lo) begin
      acc_new = scit_pkg::ACC_MIN;
    end else begin
      acc_new = acc_sum[scit_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      r  <= radius;
      px <= pos_x;
      py <= pos_y;
      pz <= pos_z;
    end
    prod <= opa * opb;
    ox   <= {1'b0, sqy} + {1'b0, sqz};
    oy   <= {1'b0, sqx} + {1'b0, sqz};
    oz   <= {1'b0, sqx} + {1'b0, sqy};
    case (ctl.op.wb_sel)
      scit_pkg::WB_NONE: begin end
      scit_pkg::WB_R2:   r2   <= prod[31:0];
      scit_pkg::WB_RK:   rk   <= prod[31:0];
      scit_pkg::WB_SQX:  sqx  <= prod[30:0];
      scit_pkg::WB_SQY:  sqy  <= prod[30:0];
      scit_pkg::WB_SQZ:  sqz  <= prod[30:0];
      scit_pkg::WB_M:    m    <= m_sum[63:33];
      scit_pkg::WB_T:    t    <= t_sum[62:20];
      scit_pkg::WB_HI:   hi   <= prod[37:0];
      scit_pkg::WB_S:    s    <= s_sum[58:16];
      scit_pkg::WB_PXY:  pxy  <= prod[31:0];
      scit_pkg::WB_PXZ:  pxz  <= prod[31:0];
      scit_pkg::WB_PYZ:  pyz  <= prod[31:0];
      scit_pkg::WB_TD:   term <= term_sum[scit_pkg::PROD_W-1:16];
      scit_pkg::WB_TO:   term <= term_sum[scit_pkg::PROD_W-1:16];
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < scit_pkg::NUM_SUMS; i++) begin
        acc[i] <= '0;
      end
    end else if (ctl.emit) begin
      for (int i = 0; i < scit_pkg::NUM_SUMS; i++) begin
        acc[i] <= '0;
      end
    end else if (ctl.op.acc_en) begin
      acc[ctl.op.acc_idx] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      inertia_xx <= acc[scit_pkg::SUM_XX];
      inertia_yy <= acc[scit_pkg::SUM_YY];
      inertia_zz <= acc[scit_pkg::SUM_ZZ];
      inertia_xy <= acc[scit_pkg::SUM_XY];
      inertia_xz <= acc[scit_pkg::SUM_XZ];
      inertia_yz <= acc[scit_pkg::SUM_YZ];
    end
  end

endmodule

@@ rtl/sphere_cluster_inertia_tensor.sv @@
// Sphere cluster inertia tensor: accumulates spheres of a rigid body and emits its tensor.
//
// Input channel (in_valid / in_stall): one word per sphere, radius in unsigned Q4.12 and
// the offset pos_x, pos_y, pos_z in signed Q6.10; last_atom marks the final sphere.
// A word is taken on a clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): one word per body, the six tensor entries in
// signed Q28.20, saturated, taken on an edge with out_valid high and out_stall low.
// Each sphere runs 20 steps through one shared 33 x 33 multiplier, which forms 18
// products in turn; in_stall stays high until the steps end, so no new word is taken
// before the previous sphere is through. For a last sphere the emit state then moves
// the sums into the output register and raises out_valid, and the next word can be
// taken once the controller is back in idle.
// A result held by out_stall stays in the output register while the next sphere is
// accumulated; the transfer into it waits only if that earlier result is still there.
// Synchronous reset clears the control state, drops out_valid and zeroes all six sums.
module sphere_cluster_inertia_tensor (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic        [15:0]                 radius,
  input  logic signed [15:0]                 pos_x,
  input  logic signed [15:0]                 pos_y,
  input  logic signed [15:0]                 pos_z,
  input  logic                               last_atom,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [scit_pkg::ACC_W-1:0]  inertia_xx,
  output logic signed [scit_pkg::ACC_W-1:0]  inertia_yy,
  output logic signed [scit_pkg::ACC_W-1:0]  inertia_zz,
  output logic signed [scit_pkg::ACC_W-1:0]  inertia_xy,
  output logic signed [scit_pkg::ACC_W-1:0]  inertia_xz,
  output logic signed [scit_pkg::ACC_W-1:0]  inertia_yz
);

  scit_pkg::ctl_t ctl;

  scit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_atom (last_atom),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  scit_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .radius     (radius),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .inertia_xx (inertia_xx),
    .inertia_yy (inertia_yy),
    .inertia_zz (inertia_zz),
    .inertia_xy (inertia_xy),
    .inertia_xz (inertia_xz),
    .inertia_yz (inertia_yz)
  );

endmodule

@@ rtl/scit_checker.sv @@
// Port-level checker for the sphere cluster inertia tensor block, bound to the top level.
module scit_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [scit_pkg::ACC_W-1:0]  inertia_xx,
  input logic signed [scit_pkg::ACC_W-1:0]  inertia_yy,
  input logic signed [scit_pkg::ACC_W-1:0]  inertia_zz,
  input logic signed [scit_pkg::ACC_W-1:0]  inertia_xy,
  input logic signed [scit_pkg::ACC_W-1:0]  inertia_xz,
  input logic signed [scit_pkg::ACC_W-1:0]  inertia_yz
);

  // An accepted word leaves the input side busy at the first and at the last of the twenty steps.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall ##19 in_stall)
    else $error("input side took a word before the previous sphere finished");

  // A new result only appears as the block returns to idle from a busy period.
  a_result_ends_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (!in_stall && $past(in_stall)))
    else $error("result word appeared outside the end of a sphere");

  // A stalled result word holds its value.
  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(inertia_xx) &&
      $stable(inertia_yy) && $stable(inertia_zz) && $stable(inertia_xy) &&
      $stable(inertia_xz) && $stable(inertia_yz)))
    else $error("stalled result word changed or was dropped");

endmodule

bind sphere_cluster_inertia_tensor scit_checker u_scit_checker (.*);
